// ----- sv/omni_accel_limit_scaling_assert.svh -----
// Assertion macros for the acceleration limit scaling block.
`ifndef OMNI_ACCEL_LIMIT_SCALING_ASSERT_SVH
`define OMNI_ACCEL_LIMIT_SCALING_ASSERT_SVH
`ifndef SYNTHESIS
`define OALS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define OALS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define OALS_ASSERT(lbl, prop)
`define OALS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- sv/oals_pkg.sv -----
// Shared types, constants and helpers for the acceleration limit scaling block.
`timescale 1ns / 1ps
package oals_pkg;

  typedef enum logic [2:0] {
    REG_LINEAR_MASS     = 3'd0,
    REG_ROT_MASS_RADIUS = 3'd1,
    REG_TORQUE_PER_FORCE = 3'd2,
    REG_VOLTS_PER_TORQUE = 3'd3,
    REG_VOLTS_PER_SPEED = 3'd4,
    REG_VOLTAGE_STEP    = 3'd5
  } reg_idx_e;

  localparam logic [31:0] REG_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] linear_mass;
    logic [31:0] rot_mass_radius;
    logic [31:0] torque_per_force;
    logic [31:0] volts_per_torque;
    logic [31:0] volts_per_speed;
    logic [31:0] voltage_step_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0]       accel_x;
    logic [31:0]       accel_y;
    logic [31:0]       accel_angular;
    logic [3:0][15:0]  wheel_speed;
    logic [23:0]       battery;
  } item_t;

  // largest |drive| and |drive + back-EMF| over the four wheels, plus the battery voltage
  typedef struct packed {
    logic [31:0] max_drive;
    logic [32:0] max_appl;
    logic [23:0] battery;
  } peak_t;

  typedef struct packed {
    logic [31:0] slip_q;
    logic        slip_sat;
    logic [31:0] batt_q;
    logic        batt_sat;
  } ratio_t;

  // signed Q1.16 coupling matrix, one column per wheel
  localparam logic signed [16:0] KX [4] = '{-17'sd22924, -17'sd19785, 17'sd19785, 17'sd22924};
  localparam logic signed [16:0] KY [4] = '{17'sd25585, -17'sd25585, -17'sd25585, 17'sd25585};
  localparam logic signed [16:0] KT [4] = '{17'sd18094, 17'sd14674, 17'sd14674, 17'sd18094};

  localparam int unsigned DP_STAGES  = 7;
  localparam int unsigned DIV_STAGES = 17;  // one setup stage plus sixteen 2-bit stages

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // drop 16 fraction bits toward minus infinity, clamp to signed 32 bits
  function automatic logic signed [31:0] floor_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    if (s > S32_MAX) return 32'sh7FFF_FFFF;
    if (s < S32_MIN) return 32'sh8000_0000;
    return s[31:0];
  endfunction

endpackage

// ----- sv/oals_datapath.sv -----
// Force, wheel matrix, torque, drive voltage, back-EMF and peak search pipeline.
`timescale 1ns / 1ps
module oals_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oals_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  oals_pkg::item_t  item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output oals_pkg::peak_t  peak_o
);

  localparam int unsigned NS = oals_pkg::DP_STAGES;

  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  // stage 0: mass products
  logic signed [63:0] px_q, py_q, pt_q;
  logic [3:0][15:0]   spd0_q;
  logic [23:0]        bat0_q;
  // stage 1: forces, back-EMF products
  logic signed [31:0] fx_q, fy_q, ft_q;
  logic signed [47:0] emfp1_q [4];
  logic [23:0]        bat1_q;
  // stage 2: wheel forces
  logic signed [48:0] wf_q [4];
  logic signed [47:0] emfp2_q [4];
  logic [23:0]        bat2_q;
  // stage 3: torque products, back-EMF
  logic signed [63:0] tp_q [4];
  logic signed [31:0] emf3_q [4];
  logic [23:0]        bat3_q;
  // stage 4: drive products
  logic signed [63:0] dp_q [4];
  logic signed [31:0] emf4_q [4];
  logic [23:0]        bat4_q;
  // stage 5: magnitudes
  logic [31:0]        ad_q [4];
  logic [32:0]        aa_q [4];
  logic [23:0]        bat5_q;
  // stage 6: peaks
  logic [31:0]        mxd_q;
  logic [32:0]        mxa_q;
  logic [23:0]        bat6_q;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign peak_o      = '{max_drive: mxd_q, max_appl: mxa_q, battery: bat6_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // combinational per-stage results
  logic signed [63:0] px_d, py_d, pt_d;
  logic signed [47:0] emfp1_d [4];
  logic signed [48:0] wf_d [4];
  logic signed [63:0] tp_d [4];
  logic signed [31:0] emf3_d [4];
  logic signed [63:0] dp_d [4];
  logic [31:0]        ad_d [4];
  logic [32:0]        aa_d [4];
  logic [31:0]        mxd_d, mxd01, mxd23;
  logic [32:0]        mxa_d, mxa01, mxa23;

  always_comb begin
    logic signed [63:0] fx64, fy64, ft64, sum, prod, f64;
    logic signed [31:0] force_w, torque_w, drive_w;
    logic signed [32:0] appl;
    logic signed [33:0] neg;
    px_d = $signed({{32{item_i.accel_x[31]}}, item_i.accel_x})
         * $signed({32'd0, cfg_i.linear_mass});
    py_d = $signed({{32{item_i.accel_y[31]}}, item_i.accel_y})
         * $signed({32'd0, cfg_i.linear_mass});
    pt_d = $signed({{32{item_i.accel_angular[31]}}, item_i.accel_angular})
         * $signed({32'd0, cfg_i.rot_mass_radius});
    fx64 = {{32{fx_q[31]}}, fx_q};
    fy64 = {{32{fy_q[31]}}, fy_q};
    ft64 = {{32{ft_q[31]}}, ft_q};
    for (int w = 0; w < 4; w++) begin
      prod = $signed({{48{spd0_q[w][15]}}, spd0_q[w]})
           * $signed({32'd0, cfg_i.volts_per_speed});
      emfp1_d[w] = prod[47:0];
      sum = fx64 * $signed({{47{oals_pkg::KX[w][16]}}, oals_pkg::KX[w]})
          + fy64 * $signed({{47{oals_pkg::KY[w][16]}}, oals_pkg::KY[w]})
          + ft64 * $signed({{47{oals_pkg::KT[w][16]}}, oals_pkg::KT[w]});
      wf_d[w] = sum[48:0];
      f64 = {{15{wf_q[w][48]}}, wf_q[w]};
      force_w = oals_pkg::floor_sat(f64);
      tp_d[w] = $signed({{32{force_w[31]}}, force_w})
              * $signed({32'd0, cfg_i.torque_per_force});
      emf3_d[w] = oals_pkg::floor_sat({{16{emfp2_q[w][47]}}, emfp2_q[w]});
      torque_w = oals_pkg::floor_sat(tp_q[w]);
      dp_d[w] = $signed({{32{torque_w[31]}}, torque_w})
              * $signed({32'd0, cfg_i.volts_per_torque});
      drive_w = oals_pkg::floor_sat(dp_q[w]);
      neg = 34'sd0 - $signed({{2{drive_w[31]}}, drive_w});
      ad_d[w] = drive_w[31] ? neg[31:0] : drive_w;
      appl = $signed({drive_w[31], drive_w}) + $signed({emf4_q[w][31], emf4_q[w]});
      neg = 34'sd0 - $signed({appl[32], appl});
      aa_d[w] = appl[32] ? neg[32:0] : appl;
    end
    mxd01 = (ad_q[1] > ad_q[0]) ? ad_q[1] : ad_q[0];
    mxd23 = (ad_q[3] > ad_q[2]) ? ad_q[3] : ad_q[2];
    mxd_d = (mxd23 > mxd01) ? mxd23 : mxd01;
    mxa01 = (aa_q[1] > aa_q[0]) ? aa_q[1] : aa_q[0];
    mxa23 = (aa_q[3] > aa_q[2]) ? aa_q[3] : aa_q[2];
    mxa_d = (mxa23 > mxa01) ? mxa23 : mxa01;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pt_q   <= pt_d;
      spd0_q <= item_i.wheel_speed;
      bat0_q <= item_i.battery;
    end
    if (adv[1]) begin
      fx_q    <= oals_pkg::floor_sat(px_q);
      fy_q    <= oals_pkg::floor_sat(py_q);
      ft_q    <= oals_pkg::floor_sat(pt_q);
      emfp1_q <= emfp1_d;
      bat1_q  <= bat0_q;
    end
    if (adv[2]) begin
      wf_q    <= wf_d;
      emfp2_q <= emfp1_q;
      bat2_q  <= bat1_q;
    end
    if (adv[3]) begin
      tp_q   <= tp_d;
      emf3_q <= emf3_d;
      bat3_q <= bat2_q;
    end
    if (adv[4]) begin
      dp_q   <= dp_d;
      emf4_q <= emf3_q;
      bat4_q <= bat3_q;
    end
    if (adv[5]) begin
      ad_q   <= ad_d;
      aa_q   <= aa_d;
      bat5_q <= bat4_q;
    end
    if (adv[6]) begin
      mxd_q  <= mxd_d;
      mxa_q  <= mxa_d;
      bat6_q <= bat5_q;
    end
  end

endmodule

// ----- sv/oals_div.sv -----
// Pipelined two-lane restoring divider for the slip and battery ratios.
`timescale 1ns / 1ps
`include "omni_accel_limit_scaling_assert.svh"
module oals_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      step_limit_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  oals_pkg::peak_t  peak_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output oals_pkg::ratio_t ratio_o
);

  localparam int unsigned NS = oals_pkg::DIV_STAGES;

  // lane 0: slip ratio, lane 1: battery ratio
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;
  logic [32:0]   rem_q [NS][2];
  logic [31:0]   lo_q  [NS][2];
  logic [32:0]   den_q [NS][2];
  logic [31:0]   quo_q [NS][2];
  logic          sat_q [NS][2];

  logic [15:0] hi_in [2];
  logic [31:0] lo_in [2];
  logic [32:0] den_in [2];

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

  // numerator is value << 16, split into bits 32 and up and the low 32 bits
  always_comb begin
    hi_in[0]  = step_limit_i[31:16];
    lo_in[0]  = {step_limit_i[15:0], 16'd0};
    den_in[0] = {1'b0, peak_i.max_drive};
    hi_in[1]  = {8'd0, peak_i.battery[23:16]};
    lo_in[1]  = {peak_i.battery[15:0], 16'd0};
    den_in[1] = peak_i.max_appl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [33:0] t;
    logic [32:0] r;
    logic [31:0] lo, q;
    for (int l = 0; l < 2; l++) begin
      if (adv[0]) begin
        // quotient needs more than 32 bits (or divisor is zero)
        sat_q[0][l] <= {17'd0, hi_in[l]} >= den_in[l];
        rem_q[0][l] <= {17'd0, hi_in[l]};
        lo_q[0][l]  <= lo_in[l];
        den_q[0][l] <= den_in[l];
        quo_q[0][l] <= '0;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          r  = rem_q[k-1][l];
          lo = lo_q[k-1][l];
          q  = quo_q[k-1][l];
          for (int s = 0; s < 2; s++) begin
            t  = {r, lo[31]};
            lo = {lo[30:0], 1'b0};
            if (t >= {1'b0, den_q[k-1][l]}) begin
              t = t - {1'b0, den_q[k-1][l]};
              q = {q[30:0], 1'b1};
            end else begin
              q = {q[30:0], 1'b0};
            end
            r = t[32:0];
          end
          rem_q[k][l] <= r;
          lo_q[k][l]  <= lo;
          quo_q[k][l] <= q;
          den_q[k][l] <= den_q[k-1][l];
          sat_q[k][l] <= sat_q[k-1][l];
        end
      end
    end
  end

  assign ratio_o = '{
    slip_q:   sat_q[NS-1][0] ? 32'hFFFF_FFFF : quo_q[NS-1][0],
    slip_sat: sat_q[NS-1][0],
    batt_q:   sat_q[NS-1][1] ? 32'hFFFF_FFFF : quo_q[NS-1][1],
    batt_sat: sat_q[NS-1][1]
  };

  `OALS_ASSERT(a_slip_rem_bound, v_q[NS-1] && !sat_q[NS-1][0] |-> rem_q[NS-1][0] < den_q[NS-1][0])
  `OALS_ASSERT(a_batt_rem_bound, v_q[NS-1] && !sat_q[NS-1][1] |-> rem_q[NS-1][1] < den_q[NS-1][1])
  `OALS_ASSERT(a_div_flow, v_q[NS-1] && !out_ready_i |=> v_q[NS-1] && $stable(quo_q[NS-1][1]))

endmodule

// ----- sv/omni_accel_limit_scaling.sv -----
// Top level of the acceleration limit scaling block: registers, pipeline, result stage.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one request: accel_x/y/angular
//    (signed Q16.16), four signed wheel encoder speeds and the battery voltage (Q8.16).
//  - Output channel (out_valid_o / out_ready_i) returns one transaction per request:
//    scale (Q16.16), battery_limited and saturated, in request order.
//  - A request passes 25 registers: 7 stages of multiply/saturate/peak search,
//    17 divider stages (a setup stage, then sixteen stages of 2 quotient bits, both
//    ratios in parallel lanes) and the result register, which drives out_valid_o.
//  - Throughput is one transaction per cycle while the receiver does not stall;
//    every stage holds its own valid bit.
//  - When the receiver stalls, stages fill up behind the result register and
//    in_ready_o drops only once every stage holds a transaction; bubbles are squeezed.
//  - The APB port writes the six 32-bit registers at byte addresses 0x00..0x14;
//    writes take effect immediately and must happen only while the block is empty.
//  - Reset clears all valid bits and sets every register to 1.0 (0x0001_0000).
`timescale 1ns / 1ps
`include "omni_accel_limit_scaling_assert.svh"
module omni_accel_limit_scaling (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] accel_x_i,
  input  logic [31:0] accel_y_i,
  input  logic [31:0] accel_angular_i,
  input  logic [15:0] wheel_speed_0_i,
  input  logic [15:0] wheel_speed_1_i,
  input  logic [15:0] wheel_speed_2_i,
  input  logic [15:0] wheel_speed_3_i,
  input  logic [23:0] battery_voltage_i,
  // result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] scale_o,
  output logic        battery_limited_o,
  output logic        saturated_o
);

  oals_pkg::cfg_t   cfg_q;
  oals_pkg::item_t  item;
  oals_pkg::peak_t  peak;
  oals_pkg::ratio_t ratio;
  oals_pkg::reg_idx_e widx;

  logic dp_ready, dp_valid, div_valid, div_ready;
  logic out_valid_q, out_adv;
  logic [31:0] scale_q;
  logic batt_lim_q, sat_q;
  logic pick_batt;

  // ---------------- register file ----------------
  assign pready = 1'b1;
  assign widx   = oals_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{default: oals_pkg::REG_RESET};
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        oals_pkg::REG_LINEAR_MASS:      cfg_q.linear_mass        <= pwdata;
        oals_pkg::REG_ROT_MASS_RADIUS:  cfg_q.rot_mass_radius    <= pwdata;
        oals_pkg::REG_TORQUE_PER_FORCE: cfg_q.torque_per_force   <= pwdata;
        oals_pkg::REG_VOLTS_PER_TORQUE: cfg_q.volts_per_torque   <= pwdata;
        oals_pkg::REG_VOLTS_PER_SPEED:  cfg_q.volts_per_speed    <= pwdata;
        oals_pkg::REG_VOLTAGE_STEP:     cfg_q.voltage_step_limit <= pwdata;
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      oals_pkg::REG_LINEAR_MASS:      prdata = cfg_q.linear_mass;
      oals_pkg::REG_ROT_MASS_RADIUS:  prdata = cfg_q.rot_mass_radius;
      oals_pkg::REG_TORQUE_PER_FORCE: prdata = cfg_q.torque_per_force;
      oals_pkg::REG_VOLTS_PER_TORQUE: prdata = cfg_q.volts_per_torque;
      oals_pkg::REG_VOLTS_PER_SPEED:  prdata = cfg_q.volts_per_speed;
      oals_pkg::REG_VOLTAGE_STEP:     prdata = cfg_q.voltage_step_limit;
      default:                        prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  assign item = '{
    accel_x:       accel_x_i,
    accel_y:       accel_y_i,
    accel_angular: accel_angular_i,
    wheel_speed:   {wheel_speed_3_i, wheel_speed_2_i, wheel_speed_1_i, wheel_speed_0_i},
    battery:       battery_voltage_i
  };

  oals_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (dp_ready),
    .item_i      (item),
    .out_valid_o (dp_valid),
    .out_ready_i (div_ready),
    .peak_o      (peak)
  );

  oals_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_limit_i (cfg_q.voltage_step_limit),
    .in_valid_i   (dp_valid),
    .in_ready_o   (div_ready),
    .peak_i       (peak),
    .out_valid_o  (div_valid),
    .out_ready_i  (out_adv),
    .ratio_o      (ratio)
  );

  assign in_ready_o = dp_ready;

  // ---------------- result register ----------------
  // on a tie the battery ratio wins
  assign pick_batt = !(ratio.batt_q > ratio.slip_q);
  assign out_adv   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      scale_q    <= pick_batt ? ratio.batt_q : ratio.slip_q;
      batt_lim_q <= pick_batt;
      sat_q      <= pick_batt ? ratio.batt_sat : ratio.slip_sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scale_o           = scale_q;
  assign battery_limited_o = batt_lim_q;
  assign saturated_o       = sat_q;

  `OALS_ASSERT(a_sat_gives_max, out_valid_o && saturated_o |-> scale_o == 32'hFFFF_FFFF)
  `OALS_ASSERT(a_slip_below_max, out_valid_o && !battery_limited_o |-> scale_o != 32'hFFFF_FFFF)
  `OALS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(scale_o))

endmodule
